### rtl/tkd_pkg.sv
// shared types, constants and decode tables for the terminal key decoder
`default_nettype none
package tkd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SCREEN_ROWS = 2'd0;
  localparam logic [1:0] REG_SCREEN_COLS = 2'd1;
  localparam logic [1:0] REG_FILE_LINES  = 2'd2;

  // register reset values
  localparam logic [7:0]  RST_SCREEN_ROWS = 8'd24;
  localparam logic [7:0]  RST_SCREEN_COLS = 8'd80;
  localparam logic [15:0] RST_FILE_LINES  = 16'd0;

  // depth of the key queue between decoder and cursor unit
  localparam int QUEUE_DEPTH_DEF = 2;

  // bytes of interest
  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_CSI    = 8'h5b; // '['
  localparam logic [7:0] BYTE_SS3    = 8'h4f; // 'O'
  localparam logic [7:0] BYTE_TILDE  = 8'h7e;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_NINE   = 8'h39;
  localparam logic [7:0] CTRL_MASK   = 8'h1f;
  localparam logic [7:0] BYTE_CTRL_Q = 8'h71 & CTRL_MASK;

  // key codes
  localparam logic [8:0] KEY_ESC   = 9'd27;
  localparam logic [8:0] KEY_QUIT  = {1'b0, BYTE_CTRL_Q};
  localparam logic [8:0] KEY_UP    = 9'd256;
  localparam logic [8:0] KEY_DOWN  = 9'd257;
  localparam logic [8:0] KEY_LEFT  = 9'd258;
  localparam logic [8:0] KEY_RIGHT = 9'd259;
  localparam logic [8:0] KEY_PGUP  = 9'd260;
  localparam logic [8:0] KEY_PGDN  = 9'd261;
  localparam logic [8:0] KEY_HOME  = 9'd262;
  localparam logic [8:0] KEY_END   = 9'd263;
  localparam logic [8:0] KEY_DEL   = 9'd264;

  // escape parser states
  typedef enum logic [1:0] {
    PS_IDLE,
    PS_ESC,
    PS_SECOND,
    PS_TILDE
  } parse_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  key_code;
    logic [7:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic [15:0] top_line;
    logic        quit;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  screen_rows;
    logic [7:0]  screen_cols;
    logic [15:0] file_lines;
  } cfg_t;

  // final byte of ESC [ x
  function automatic logic [8:0] csi_final(input logic [7:0] b);
    logic [8:0] k;
    unique case (b)
      8'h41:   k = KEY_UP;
      8'h42:   k = KEY_DOWN;
      8'h43:   k = KEY_RIGHT;
      8'h44:   k = KEY_LEFT;
      8'h48:   k = KEY_HOME;
      8'h46:   k = KEY_END;
      default: k = KEY_ESC;
    endcase
    return k;
  endfunction

  // digit of ESC [ digit ~
  function automatic logic [8:0] tilde_key(input logic [7:0] d);
    logic [8:0] k;
    unique case (d)
      8'h31, 8'h37: k = KEY_HOME;
      8'h34, 8'h38: k = KEY_END;
      8'h35:        k = KEY_PGUP;
      8'h36:        k = KEY_PGDN;
      8'h33:        k = KEY_DEL;
      default:      k = KEY_ESC;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### rtl/tkd_front.sv
// escape sequence decoder: accepts bytes and timeouts, pushes decoded keys
`default_nettype none
module tkd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire tkd_pkg::in_item_t in_data,
  input  wire logic            queue_full,
  output logic                 in_stall,
  output logic                 push,
  output logic [8:0]           push_key
);
  import tkd_pkg::*;

  parse_state_t state_r, state_nxt;
  logic [7:0]   held_r, held_nxt;
  logic         stopped_r, stopped_nxt;
  logic         accept;
  logic         has_key;
  logic [8:0]   key;
  logic         is_digit;

  // once stopped every item is taken and dropped
  assign in_stall = !stopped_r && queue_full;
  assign accept   = in_valid && !in_stall;
  assign is_digit = (in_data.data_byte >= BYTE_ZERO) && (in_data.data_byte <= BYTE_NINE);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= PS_IDLE;
      held_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // parser next state and key decode
  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    has_key   = 1'b0;
    key       = KEY_ESC;
    if (accept && !stopped_r) begin
      unique case (state_r)
        PS_IDLE: begin
          if (!in_data.mode) begin
            if (in_data.data_byte == BYTE_ESC) begin
              state_nxt = PS_ESC;
            end else begin
              has_key = 1'b1;
              key     = {1'b0, in_data.data_byte};
            end
          end
        end
        PS_ESC: begin
          if (in_data.mode) begin
            state_nxt = PS_IDLE;
            has_key   = 1'b1;
          end else begin
            held_nxt  = in_data.data_byte;
            state_nxt = PS_SECOND;
          end
        end
        PS_SECOND: begin
          state_nxt = PS_IDLE;
          has_key   = 1'b1;
          if (!in_data.mode) begin
            if (held_r == BYTE_CSI) begin
              if (is_digit) begin
                held_nxt  = in_data.data_byte;
                state_nxt = PS_TILDE;
                has_key   = 1'b0;
              end else begin
                key = csi_final(in_data.data_byte);
              end
            end else if (held_r == BYTE_SS3) begin
              if (in_data.data_byte == 8'h48) begin
                key = KEY_HOME;
              end else if (in_data.data_byte == 8'h46) begin
                key = KEY_END;
              end
            end
          end
        end
        PS_TILDE: begin
          state_nxt = PS_IDLE;
          has_key   = 1'b1;
          if (!in_data.mode && in_data.data_byte == BYTE_TILDE) begin
            key = tilde_key(held_r);
          end
        end
        default: state_nxt = PS_IDLE;
      endcase
    end
  end

  assign push        = has_key;
  assign push_key    = key;
  assign stopped_nxt = stopped_r || (has_key && key == KEY_QUIT);

endmodule
`default_nettype wire

### rtl/tkd_queue.sv
// small key queue between decoder and cursor unit
`default_nettype none
module tkd_queue #(
  parameter int DEPTH = tkd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [8:0] push_key,
  input  wire logic       pop,
  output logic [8:0]      pop_key,
  output logic            full,
  output logic            empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  logic [8:0]    entries_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == FULLC);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_key = entries_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == LAST) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == LAST) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_r] <= push_key;
  end

endmodule
`default_nettype wire

### rtl/tkd_back.sv
// cursor unit: applies each key to the cursor and registers the result
`default_nettype none
module tkd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tkd_pkg::cfg_t cfg,
  input  wire logic          queue_empty,
  input  wire logic [8:0]    key,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tkd_pkg::out_item_t out_data
);
  import tkd_pkg::*;

  logic [7:0]  row_r, row_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [15:0] top_r, top_nxt;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [7:0]  rows_eff, cols_eff, bottom, n;
  logic [7:0]  up_row, dn_row, up_rem, dn_rem, d;
  logic [15:0] up_top, dn_top;
  logic signed [17:0] limit, top_s, room;
  logic [15:0] rem16, room16;
  logic        is_page;

  assign pop       = !queue_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rows_eff = (cfg.screen_rows == 8'd0) ? 8'd1 : cfg.screen_rows;
  assign cols_eff = (cfg.screen_cols == 8'd0) ? 8'd1 : cfg.screen_cols;
  assign bottom   = rows_eff - 8'd1;
  assign is_page  = (key == KEY_PGUP) || (key == KEY_PGDN);
  assign n        = is_page ? rows_eff : 8'd1;

  // upward move of n rows, scrolling past the top
  always_comb begin
    up_rem = n - row_r;
    if (n <= row_r) begin
      up_row = row_r - n;
      up_top = top_r;
    end else begin
      up_row = 8'd0;
      up_top = (top_r > {8'd0, up_rem}) ? top_r - {8'd0, up_rem} : 16'd0;
    end
  end

  // downward move of n rows, scrolling bounded by the file length
  always_comb begin
    d      = bottom - row_r;
    dn_row = row_r;
    dn_rem = n;
    dn_top = top_r;
    limit  = $signed({2'b00, cfg.file_lines}) - $signed({10'd0, rows_eff});
    top_s  = $signed({2'b00, top_r});
    room   = limit - top_s;
    room16 = room[15:0];
    rem16  = {8'd0, dn_rem};
    if (row_r < bottom) begin
      if (n <= d) begin
        dn_row = row_r + n;
      end else begin
        dn_row = bottom;
        dn_rem = n - d;
      end
    end
    rem16 = {8'd0, dn_rem};
    if (!(row_r < bottom && n <= d) && (top_s < limit)) begin
      dn_top = top_r + ((rem16 < room16) ? rem16 : room16);
    end
  end

  // select the move for this key
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    top_nxt = top_r;
    unique case (key)
      KEY_HOME:  col_nxt = 8'd0;
      KEY_END:   col_nxt = cols_eff - 8'd1;
      KEY_UP, KEY_PGUP: begin
        row_nxt = up_row;
        top_nxt = up_top;
      end
      KEY_DOWN, KEY_PGDN: begin
        row_nxt = dn_row;
        top_nxt = dn_top;
      end
      KEY_LEFT:  if (col_r != 8'd0) col_nxt = col_r - 8'd1;
      KEY_RIGHT: if (col_r < cols_eff - 8'd1) col_nxt = col_r + 8'd1;
      default: ;
    endcase
  end

  // cursor state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        row_r       <= row_nxt;
        col_r       <= col_nxt;
        top_r       <= top_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_r.key_code   <= key;
      out_r.cursor_row <= row_nxt;
      out_r.cursor_col <= col_nxt;
      out_r.top_line   <= top_nxt;
      out_r.quit       <= (key == KEY_QUIT);
    end
  end

endmodule
`default_nettype wire

### rtl/terminal_key_decoder_cursor.sv
// top level of the terminal key decoder with cursor tracking
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | in_item_t  (mode, data_byte)
//   out_    | output    | out_valid / out_stall| out_item_t (key, cursor, top line, quit)
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one input item per cycle while in_stall is low; a key is decoded as its last byte is
// taken, held in the queue, then applied by the cursor unit into the output register
// synchronous active-low reset clears parser, queue, cursor and the stop flag
// out_stall backs up into the key queue; in_stall rises only when the queue is full
// after ctrl-q every input is taken and dropped until reset
`default_nettype none
module terminal_key_decoder_cursor #(
  parameter int QUEUE_DEPTH = tkd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tkd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tkd_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import tkd_pkg::*;

  cfg_t       cfg_r;
  logic       push, pop, q_full, q_empty;
  logic [8:0] push_key, pop_key;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_rows <= RST_SCREEN_ROWS;
      cfg_r.screen_cols <= RST_SCREEN_COLS;
      cfg_r.file_lines  <= RST_FILE_LINES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_ROWS: cfg_r.screen_rows <= cfg_data[7:0];
        REG_SCREEN_COLS: cfg_r.screen_cols <= cfg_data[7:0];
        REG_FILE_LINES:  cfg_r.file_lines  <= cfg_data;
        default: ;
      endcase
    end
  end

  // decoder
  tkd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .queue_full (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_key   (push_key)
  );

  // key queue
  tkd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_key (push_key),
    .pop      (pop),
    .pop_key  (pop_key),
    .full     (q_full),
    .empty    (q_empty)
  );

  // cursor unit
  tkd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .queue_empty (q_empty),
    .key         (pop_key),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

### rtl/tkd_checker.sv
// port-level checker for the terminal key decoder, bound to the top level
`default_nettype none
module tkd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire tkd_pkg::out_item_t out_data
);
  import tkd_pkg::*;

  logic        quit_seen_r;
  logic        have_last_r;
  logic [15:0] last_top_r;
  logic        out_xfer;
  logic        moves_row;

  assign out_xfer  = out_valid && !out_stall;
  assign moves_row = (out_data.key_code == KEY_UP) || (out_data.key_code == KEY_DOWN) ||
                     (out_data.key_code == KEY_PGUP) || (out_data.key_code == KEY_PGDN);

  // history of delivered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quit_seen_r <= 1'b0;
      have_last_r <= 1'b0;
      last_top_r  <= '0;
    end else if (out_xfer) begin
      quit_seen_r <= quit_seen_r || out_data.quit;
      have_last_r <= 1'b1;
      last_top_r  <= out_data.top_line;
    end
  end

  // nothing follows a delivered quit
  a_silent_after_quit: assert property (@(posedge clk) disable iff (!rst_n)
    quit_seen_r |-> !out_valid)
    else $error("result after quit");

  // key codes stay within the defined range
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.key_code <= KEY_DEL)
    else $error("key code out of range");

  // only vertical keys scroll
  a_scroll_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && have_last_r && !moves_row) |-> out_data.top_line == last_top_r)
    else $error("top line changed on a non-vertical key");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind terminal_key_decoder_cursor tkd_checker u_tkd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

### test/tb_top.sv
// self-checking testbench for terminal_key_decoder_cursor: key decode, cursor and scroll tracking
`timescale 1ns / 1ps
module tb_top;
  import tkd_pkg::*;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  // final bytes of the escape forms
  localparam logic [7:0] CH_UP    = "A";
  localparam logic [7:0] CH_DOWN  = "B";
  localparam logic [7:0] CH_RIGHT = "C";
  localparam logic [7:0] CH_LEFT  = "D";
  localparam logic [7:0] CH_HOME  = "H";
  localparam logic [7:0] CH_END   = "F";

  // digits of ESC [ digit ~
  localparam logic [7:0] DIG_HOME     = "1";
  localparam logic [7:0] DIG_DEL      = "3";
  localparam logic [7:0] DIG_END      = "4";
  localparam logic [7:0] DIG_PGUP     = "5";
  localparam logic [7:0] DIG_PGDN     = "6";
  localparam logic [7:0] DIG_HOME_ALT = "7";
  localparam logic [7:0] DIG_END_ALT  = "8";
  localparam logic [7:0] DIG_UNUSED   = "9";

  // stands in for ctrl-q wherever stopping the block is not wanted
  localparam logic [7:0] QUIT_STANDIN = "Q";

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 115;
  localparam int DRAIN_PAD   = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    logic      has_key;
    out_item_t want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  terminal_key_decoder_cursor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow state of the decoder and cursor
  parse_state_t ps_q = PS_IDLE;
  logic [7:0]   held_q = '0;
  int           row_q = 0;
  int           col_q = 0;
  int           top_q = 0;
  bit           running_q = 1'b1;
  int           rows_cfg = RST_SCREEN_ROWS;
  int           cols_cfg = RST_SCREEN_COLS;
  int           lines_cfg = RST_FILE_LINES;

  out_item_t    pending_keys[$];
  out_item_t    oldest;
  in_item_t     seq_q[$];
  script_row_t  script[$];
  int           mismatches = 0;
  int           burst_left = 0;
  int           stall_style = 0;
  int unsigned  cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // append to the stimulus and expectation queues
  function automatic void queue_item(input in_item_t it);
    seq_q.insert(seq_q.size(), it);
  endfunction

  function automatic void expect_result(input out_item_t r);
    pending_keys.insert(pending_keys.size(), r);
  endfunction

  function automatic int rows_eff();
    return (rows_cfg == 0) ? 1 : rows_cfg;
  endfunction

  function automatic int cols_eff();
    return (cols_cfg == 0) ? 1 : cols_cfg;
  endfunction

  // n single up moves, scrolling once row 0 is reached
  function automatic void scroll_up(input int n);
    int rem;
    if (n <= row_q) begin
      row_q -= n;
    end else begin
      rem = n - row_q;
      row_q = 0;
      top_q = (top_q > rem) ? top_q - rem : 0;
    end
  endfunction

  // n single down moves; a row past the bottom counts as the bottom
  function automatic void scroll_down(input int n);
    int bottom;
    int rem;
    int limit;
    int room;
    bottom = rows_eff() - 1;
    rem = n;
    if (row_q < bottom) begin
      if (n <= bottom - row_q) begin
        row_q += n;
        return;
      end
      rem = n - (bottom - row_q);
      row_q = bottom;
    end
    limit = lines_cfg - rows_eff();
    if (top_q < limit) begin
      room = limit - top_q;
      top_q += (rem < room) ? rem : room;
    end
  endfunction

  // escape parser; returns 1 when a key is complete
  function automatic bit decode_key(input in_item_t it, output logic [8:0] key);
    parse_state_t st;
    logic [7:0]   b;
    st = ps_q;
    b = it.data_byte;
    key = KEY_ESC;
    if (st == PS_IDLE) begin
      if (it.mode == MODE_TIMEOUT) return 1'b0;
      if (b == BYTE_ESC) begin
        ps_q = PS_ESC;
        return 1'b0;
      end
      key = {1'b0, b};
      return 1'b1;
    end
    // inside a sequence: a timeout or an unknown form gives a plain esc
    ps_q = PS_IDLE;
    if (it.mode == MODE_TIMEOUT) return 1'b1;
    case (st)
      PS_ESC: begin
        held_q = b;
        ps_q = PS_SECOND;
        return 1'b0;
      end
      PS_SECOND: begin
        if (held_q == BYTE_CSI) begin
          if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
            held_q = b;
            ps_q = PS_TILDE;
            return 1'b0;
          end
          case (b)
            CH_UP:    key = KEY_UP;
            CH_DOWN:  key = KEY_DOWN;
            CH_RIGHT: key = KEY_RIGHT;
            CH_LEFT:  key = KEY_LEFT;
            CH_HOME:  key = KEY_HOME;
            CH_END:   key = KEY_END;
            default:  key = KEY_ESC;
          endcase
        end else if (held_q == BYTE_SS3) begin
          if (b == CH_HOME) key = KEY_HOME;
          else if (b == CH_END) key = KEY_END;
        end
      end
      default: begin
        if (b == BYTE_TILDE) begin
          case (held_q)
            DIG_HOME, DIG_HOME_ALT: key = KEY_HOME;
            DIG_END, DIG_END_ALT:   key = KEY_END;
            DIG_PGUP:               key = KEY_PGUP;
            DIG_PGDN:               key = KEY_PGDN;
            DIG_DEL:                key = KEY_DEL;
            default:                key = KEY_ESC;
          endcase
        end
      end
    endcase
    return 1'b1;
  endfunction

  // one accepted input: decode, move the cursor, build the result
  function automatic bit predict_key(input in_item_t it, output out_item_t res);
    logic [8:0] key;
    logic       quit;
    res = '0;
    quit = 1'b0;
    if (!running_q) return 1'b0;
    if (!decode_key(it, key)) return 1'b0;
    case (key)
      KEY_QUIT: begin
        running_q = 1'b0;
        quit = 1'b1;
      end
      KEY_HOME:  col_q = 0;
      KEY_END:   col_q = cols_eff() - 1;
      KEY_UP:    scroll_up(1);
      KEY_DOWN:  scroll_down(1);
      KEY_LEFT:  if (col_q != 0) col_q--;
      KEY_RIGHT: if (col_q < cols_eff() - 1) col_q++;
      KEY_PGUP:  scroll_up(rows_eff());
      KEY_PGDN:  scroll_down(rows_eff());
      default: ;
    endcase
    res.key_code   = key;
    res.cursor_row = row_q[7:0];
    res.cursor_col = col_q[7:0];
    res.top_line   = top_q[15:0];
    res.quit       = quit;
    return 1'b1;
  endfunction

  function automatic in_item_t as_byte(input logic [7:0] b);
    in_item_t it;
    it.mode = MODE_BYTE;
    it.data_byte = b;
    return it;
  endfunction

  // timeout with a random don't-care byte
  function automatic in_item_t as_timeout();
    in_item_t it;
    it.mode = MODE_TIMEOUT;
    it.data_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void plan(input logic mode, input logic [7:0] b);
    script_row_t r;
    r = '0;
    r.item.mode = mode;
    r.item.data_byte = b;
    script.insert(script.size(), r);
  endfunction

  function automatic void plan_typed(input logic mode, input logic [7:0] b, input logic has_key,
                                     input logic [8:0] key, input logic [7:0] row,
                                     input logic [7:0] col, input logic [15:0] top);
    script_row_t r;
    r = '0;
    r.item.mode = mode;
    r.item.data_byte = b;
    r.typed = 1'b1;
    r.has_key = has_key;
    r.want.key_code = key;
    r.want.cursor_row = row;
    r.want.cursor_col = col;
    r.want.top_line = top;
    script.insert(script.size(), r);
  endfunction

  // one random sequence: mostly well formed, some plain bytes, timeouts and broken forms
  function automatic void build_seq();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      queue_item(as_byte(BYTE_ESC));
      queue_item(as_byte(BYTE_CSI));
      case ($urandom_range(0, 9))
        0, 1:    queue_item(as_byte(CH_UP));
        2, 3:    queue_item(as_byte(CH_DOWN));
        4, 5:    queue_item(as_byte(CH_LEFT));
        6, 7:    queue_item(as_byte(CH_RIGHT));
        8:       queue_item(as_byte(CH_HOME));
        default: queue_item(as_byte(CH_END));
      endcase
    end else if (pick < 55) begin
      queue_item(as_byte(BYTE_ESC));
      queue_item(as_byte(BYTE_CSI));
      queue_item(as_byte(BYTE_ZERO + 8'($urandom_range(0, 9))));
      queue_item(as_byte(BYTE_TILDE));
    end else if (pick < 62) begin
      queue_item(as_byte(BYTE_ESC));
      queue_item(as_byte(BYTE_SS3));
      case ($urandom_range(0, 4))
        0, 1:    queue_item(as_byte(CH_HOME));
        2, 3:    queue_item(as_byte(CH_END));
        default: queue_item(as_byte(8'($urandom_range(0, 255))));
      endcase
    end else if (pick < 80) begin
      queue_item(as_byte(8'($urandom_range(0, 255))));
    end else if (pick < 85) begin
      queue_item(as_timeout());
    end else begin
      // broken sequences
      queue_item(as_byte(BYTE_ESC));
      case ($urandom_range(0, 4))
        0: begin
          queue_item(as_byte(8'($urandom_range(0, 255))));
          queue_item(as_byte(8'($urandom_range(0, 255))));
        end
        1: begin
          queue_item(as_byte(BYTE_CSI));
          queue_item(as_byte(BYTE_ZERO + 8'($urandom_range(0, 9))));
          queue_item(as_byte(8'($urandom_range(0, 255))));
        end
        2: queue_item(as_timeout());
        3: begin
          queue_item(as_byte(BYTE_CSI));
          queue_item(as_timeout());
        end
        default: begin
          queue_item(as_byte(BYTE_CSI));
          queue_item(as_byte(BYTE_ZERO + 8'($urandom_range(0, 9))));
          queue_item(as_timeout());
        end
      endcase
    end
  endfunction

  // send one input transfer in bursts with random gaps, then predict it
  task automatic drive(input in_item_t it, input bit quit_ok, output bit got,
                       output out_item_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
    end
    burst_left--;
    // a ctrl-q from idle would stop the block for the rest of the run
    if (!quit_ok && running_q && ps_q == PS_IDLE && it.mode == MODE_BYTE &&
        it.data_byte == BYTE_CTRL_Q)
      it.data_byte = QUIT_STANDIN;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    got = predict_key(it, res);
  endtask

  task automatic run_random(input int count);
    bit        got;
    out_item_t res;
    for (int n = 0; n < count; n++) begin
      if (seq_q.size() == 0) begin
        if ($urandom_range(0, 79) == 0) drain();
        build_seq();
      end
      drive(seq_q.pop_front(), 1'b0, got, res);
      if (got) expect_result(res);
    end
  endtask

  // stop sending until every expected key is out, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_ROWS: rows_cfg = val[7:0];
      REG_SCREEN_COLS: cols_cfg = val[7:0];
      default:         lines_cfg = val;
    endcase
  endtask

  // upper bits of the 8-bit registers carry random junk
  task automatic write_config(input logic [7:0] rows, input logic [7:0] cols,
                              input logic [15:0] lines);
    logic [15:0] v;
    v = 16'($urandom_range(0, 65535));
    v[7:0] = rows;
    write_reg(REG_SCREEN_ROWS, v);
    v = 16'($urandom_range(0, 65535));
    v[7:0] = cols;
    write_reg(REG_SCREEN_COLS, v);
    write_reg(REG_FILE_LINES, lines);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  // result side: check each transfer, stall on a changing pattern
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual key_code %0d", $time,
                 out_data.key_code);
        mismatches++;
      end else begin
        oldest = pending_keys.pop_front();
        compare_field("key_code", oldest.key_code, out_data.key_code);
        compare_field("cursor_row", oldest.cursor_row, out_data.cursor_row);
        compare_field("cursor_col", oldest.cursor_col, out_data.cursor_col);
        compare_field("top_line", oldest.top_line, out_data.top_line);
        compare_field("quit", oldest.quit, out_data.quit);
      end
    end
    if (cycles % 256 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= ((cycles % 5) < 2);
    endcase
  end

  // stimulus
  initial begin
    bit        got;
    out_item_t res;

    // directed part, register values as after reset
    plan_typed(MODE_BYTE, 8'h00, 1'b1, 9'd0, 8'd0, 8'd0, 16'd0);
    plan_typed(MODE_TIMEOUT, 8'hc3, 1'b0, '0, '0, '0, '0);
    plan_typed(MODE_BYTE, BYTE_ESC, 1'b0, '0, '0, '0, '0);
    plan_typed(MODE_BYTE, BYTE_CSI, 1'b0, '0, '0, '0, '0);
    plan_typed(MODE_BYTE, CH_DOWN, 1'b1, KEY_DOWN, 8'd1, 8'd0, 16'd0);
    plan_typed(MODE_BYTE, BYTE_ESC, 1'b0, '0, '0, '0, '0);
    plan_typed(MODE_BYTE, BYTE_CSI, 1'b0, '0, '0, '0, '0);
    plan_typed(MODE_BYTE, CH_RIGHT, 1'b1, KEY_RIGHT, 8'd1, 8'd1, 16'd0);
    plan_typed(MODE_BYTE, BYTE_ESC, 1'b0, '0, '0, '0, '0);
    plan_typed(MODE_BYTE, BYTE_SS3, 1'b0, '0, '0, '0, '0);
    plan_typed(MODE_BYTE, CH_END, 1'b1, KEY_END, 8'd1, 8'd79, 16'd0);
    plan(MODE_BYTE, BYTE_ESC);
    plan(MODE_BYTE, BYTE_CSI);
    plan(MODE_BYTE, CH_LEFT);
    plan(MODE_BYTE, BYTE_ESC);
    plan(MODE_BYTE, BYTE_CSI);
    plan(MODE_BYTE, CH_UP);
    plan(MODE_BYTE, BYTE_ESC);
    plan(MODE_BYTE, BYTE_CSI);
    plan(MODE_BYTE, DIG_PGDN);
    plan(MODE_BYTE, BYTE_TILDE);
    plan(MODE_BYTE, BYTE_ESC);
    plan(MODE_BYTE, BYTE_CSI);
    plan(MODE_BYTE, DIG_PGUP);
    plan(MODE_BYTE, BYTE_TILDE);
    plan(MODE_BYTE, BYTE_ESC);
    plan(MODE_BYTE, BYTE_CSI);
    plan(MODE_BYTE, DIG_DEL);
    plan(MODE_BYTE, BYTE_TILDE);
    plan(MODE_BYTE, BYTE_ESC);
    plan(MODE_BYTE, BYTE_SS3);
    plan(MODE_BYTE, CH_HOME);
    // timeout inside a sequence, then an unknown digit form
    plan(MODE_BYTE, BYTE_ESC);
    plan(MODE_TIMEOUT, 8'h3c);
    plan(MODE_BYTE, BYTE_ESC);
    plan(MODE_BYTE, BYTE_CSI);
    plan(MODE_BYTE, DIG_UNUSED);
    plan(MODE_BYTE, BYTE_TILDE);

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      drive(script[i].item, 1'b0, got, res);
      if (script[i].typed) begin
        if (script[i].has_key) expect_result(script[i].want);
      end else if (got) begin
        expect_result(res);
      end
    end

    // random phases over several screen and file settings
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: write_config(8'd24, 8'd80, 16'd100);
        1: write_config(8'd255, 8'd255, 16'hffff);
        // shrinks the screen under a cursor left deep by the phase before
        2: write_config(8'd5, 8'd3, 16'd40);
        3: write_config(8'd1, 8'd1, 16'd0);
        // zero screen size behaves as one
        4: write_config(8'd0, 8'd0, 16'd300);
        default: write_config(8'($urandom_range(1, 60)), 8'($urandom_range(1, 255)),
                              16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 400)));
      endcase
      run_random(PHASE_ITEMS);
    end

    // close any open sequence, then ctrl-q stops the block for good
    drain();
    drive(as_timeout(), 1'b0, got, res);
    if (got) expect_result(res);
    drive(as_byte(BYTE_CTRL_Q), 1'b1, got, res);
    if (got) expect_result(res);
    run_random(12);
    drain();
    write_config(8'd10, 8'd10, 16'd50);
    run_random(12);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_keys.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
